/* sv/disc_collision_response_macros.svh */
// ----------------------------------------------------------------------------
// disc_collision_response assertion macros
// Shared property wrappers clocked on i_clk and disabled during i_rst_n low.
// ----------------------------------------------------------------------------
`ifndef DISC_COLLISION_RESPONSE_MACROS_SVH
`define DISC_COLLISION_RESPONSE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DCR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define DCR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* sv/dcr_pkg.sv */
// ----------------------------------------------------------------------------
// dcr_pkg
// Widths, constants and types shared by the disc collision response block.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int TAG_W     = 24;
    localparam int VEL_W     = 32;
    localparam int REST_W    = 15;
    localparam int NORM_BITS = 14;
    localparam int DIVN_W    = 64;
    localparam int DIVD_W    = 33;
    localparam int DIVQ_W    = 48;

    localparam logic [REST_W-1:0] REST_RESET = 15'd16384;
    localparam logic [15:0]       ONE_Q14    = 16'd16384;
    localparam logic [16:0]       W_ONE      = 17'd65536;
    localparam logic [16:0]       W_HALF     = 17'd32768;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [VEL_W-1:0] avx;
        logic signed [VEL_W-1:0] avy;
        logic signed [VEL_W-1:0] bvx;
        logic signed [VEL_W-1:0] bvy;
    } t_side;

    typedef struct packed {
        t_side sd;
        logic  hit;
        logic  sx;
        logic  sy;
        logic  wz;
    } t_lane;

endpackage

/* sv/dcr_div.sv */
// ----------------------------------------------------------------------------
// dcr_div
// Pipelined restoring divider, one quotient bit per stage, DIVQ_W stages.
// The dividend's bits above DIVQ_W must be smaller than the divisor.
// ----------------------------------------------------------------------------
module dcr_div
    import dcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIVN_W-1:0] i_dividend,
    input  logic [DIVD_W-1:0] i_divisor,
    output logic [DIVQ_W-1:0] o_quot
);

    logic [DIVD_W-1:0] r_rem [DIVQ_W];
    logic [DIVQ_W-1:0] r_low [DIVQ_W];
    logic [DIVQ_W-1:0] r_q   [DIVQ_W];
    logic [DIVD_W-1:0] r_dvs [DIVQ_W];

    logic [DIVD_W-1:0] n_rem [DIVQ_W];
    logic [DIVQ_W-1:0] n_low [DIVQ_W];
    logic [DIVQ_W-1:0] n_q   [DIVQ_W];

    always_comb begin
        logic [DIVD_W-1:0] rem_in;
        logic [DIVQ_W-1:0] low_in;
        logic [DIVQ_W-1:0] q_in;
        logic [DIVD_W-1:0] dvs_in;
        logic [DIVD_W:0]   t;
        for (int s = 0; s < DIVQ_W; s++) begin
            if (s == 0) begin
                rem_in = DIVD_W'(i_dividend[DIVN_W-1:DIVQ_W]);
                low_in = i_dividend[DIVQ_W-1:0];
                q_in   = '0;
                dvs_in = i_divisor;
            end else begin
                rem_in = r_rem[s-1];
                low_in = r_low[s-1];
                q_in   = r_q[s-1];
                dvs_in = r_dvs[s-1];
            end
            t = {rem_in, low_in[DIVQ_W-1]};
            if (t >= {1'b0, dvs_in}) begin
                n_rem[s] = DIVD_W'(t - {1'b0, dvs_in});
                n_q[s]   = {q_in[DIVQ_W-2:0], 1'b1};
            end else begin
                n_rem[s] = t[DIVD_W-1:0];
                n_q[s]   = {q_in[DIVQ_W-2:0], 1'b0};
            end
            n_low[s] = {low_in[DIVQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIVQ_W; s++) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_q[s]   <= n_q[s];
                r_dvs[s] <= (s == 0) ? i_divisor : r_dvs[s-1];
            end
        end
    end

    assign o_quot = r_q[DIVQ_W-1];

endmodule

/* sv/disc_collision_response.sv */
// ----------------------------------------------------------------------------
// disc_collision_response
// Two-disc collision with restitution, Q16.16, one pair per cycle.
// ----------------------------------------------------------------------------
// Input channel i_valid / o_ready carries one disc pair per request; the
// output channel o_valid / i_ready returns one result request per pair, in
// order, with the tag copied. A pair that overlaps and approaches gets new
// velocities and o_collided high; otherwise velocities pass unchanged.
// From acceptance to o_valid a pair passes ten arithmetic stages,
// forty-eight stages of the bit-per-stage dividers for the projection and
// the mass weight, and the output register. Throughput is one pair per
// cycle, set by the fully pipelined multipliers and dividers, unless stalled.
// The whole pipeline advances together: when the output holds a request
// that i_ready does not take, o_ready drops and every stage holds; no
// request is lost or repeated. The user must write restitution via i_cfg_we
// / i_cfg_data only while the pipeline is empty; the block does not enforce.
// Synchronous reset clears valid bits, sets restitution to one: 16384, Q1.14.
// ----------------------------------------------------------------------------
`include "disc_collision_response_macros.svh"

module disc_collision_response
    import dcr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [REST_W-1:0]       i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [TAG_W-1:0]        i_pair_tag,
    input  logic signed [VEL_W-1:0] i_a_pos_x,
    input  logic signed [VEL_W-1:0] i_a_pos_y,
    input  logic signed [VEL_W-1:0] i_a_vel_x,
    input  logic signed [VEL_W-1:0] i_a_vel_y,
    input  logic [VEL_W-1:0]        i_a_mass,
    input  logic signed [VEL_W-1:0] i_b_pos_x,
    input  logic signed [VEL_W-1:0] i_b_pos_y,
    input  logic signed [VEL_W-1:0] i_b_vel_x,
    input  logic signed [VEL_W-1:0] i_b_vel_y,
    input  logic [VEL_W-1:0]        i_b_mass,
    input  logic [VEL_W-1:0]        i_radius_sum,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [TAG_W-1:0]        o_tag_out,
    output logic                    o_collided,
    output logic signed [VEL_W-1:0] o_new_a_vel_x,
    output logic signed [VEL_W-1:0] o_new_a_vel_y,
    output logic signed [VEL_W-1:0] o_new_b_vel_x,
    output logic signed [VEL_W-1:0] o_new_b_vel_y
);

    function automatic logic [31:0] mag33(logic signed [32:0] v);
        logic [32:0] n;
        n = v[32] ? 33'(-v) : 33'(v);
        return n[31:0];
    endfunction

    function automatic logic signed [31:0] apply(logic signed [31:0] v, logic neg,
                                                 logic [50:0] m, logic sub);
        logic signed [52:0] term;
        logic signed [52:0] r;
        term = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
        r    = sub ? 53'(v) - term : 53'(v) + term;
        if (r > 53'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (r < -53'sd2147483648) begin
            return 32'sh80000000;
        end
        return r[31:0];
    endfunction

    logic              en;
    logic [REST_W-1:0] r_rest;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= REST_RESET;
        end else if (i_cfg_we) begin
            r_rest <= i_cfg_data;
        end
    end

    // stage registers
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v, r11_v;
    logic [DIVQ_W-1:0] r_dl_v;
    t_lane             r_dl [DIVQ_W];

    t_side r1_sd, r2_sd, r3_sd, r4_sd, r5_sd, r6_sd;
    logic signed [32:0] r1_dx, r1_dy, r1_dvx, r1_dvy;
    logic [31:0] r1_am, r1_bm, r1_rs;

    logic [63:0] r2_sqx, r2_sqy, r2_rs2;
    logic signed [65:0] r2_pdx, r2_pdy;
    logic signed [32:0] r2_dx, r2_dy, r2_dvx, r2_dvy;
    logic [4:0]  r2_k;
    logic [31:0] r2_am, r2_bm;

    logic r3_hit, r4_hit, r5_hit, r6_hit;
    logic signed [14:0] r3_rx, r3_ry, r4_rx, r4_ry, r5_rx, r5_ry;
    logic signed [32:0] r3_dvx, r3_dvy;
    logic [32:0] r3_msum, r4_msum, r5_msum;
    logic [31:0] r3_bm, r4_bm, r5_bm;

    logic signed [47:0] r4_px, r4_py;
    logic [27:0] r4_nx, r4_ny;

    logic [47:0] r5_pm;
    logic [28:0] r5_n2;

    logic [61:0] r6_nx, r6_ny;
    logic [28:0] r6_n2;
    logic [DIVN_W-1:0] r6_wdiv;
    logic [DIVD_W-1:0] r6_wdvs;
    logic r6_sx, r6_sy, r6_wz;

    logic [DIVQ_W-1:0] q_x, q_y, q_w;

    t_side r7_sd, r8_sd, r9_sd, r10_sd;
    logic  r7_hit, r8_hit, r9_hit, r10_hit;
    logic  r7_sx, r7_sy, r8_sx, r8_sy, r9_sx, r9_sy, r10_sx, r10_sy;
    logic [39:0] r7_xl, r7_xh, r7_yl, r7_yh;
    logic [16:0] r7_wb, r8_wb, r8_wa;
    logic [49:0] r8_tx, r8_ty;
    logic [41:0] r9_xbl, r9_xbh, r9_ybl, r9_ybh, r9_xal, r9_xah, r9_yal, r9_yah;
    logic [50:0] r10_axm, r10_aym, r10_bxm, r10_bym;

    // stage combinational values
    logic [31:0] s2_mdx, s2_mdy, s2_m;
    logic [5:0]  s2_bl;
    logic [15:0] fac;

    always_comb begin
        s2_mdx = mag33(r1_dx);
        s2_mdy = mag33(r1_dy);
        s2_m   = (s2_mdx > s2_mdy) ? s2_mdx : s2_mdy;
        s2_bl  = '0;
        for (int i = 0; i < 32; i++) begin
            if (s2_m[i]) begin
                s2_bl = 6'(i + 1);
            end
        end
    end

    assign fac = ONE_Q14 + 16'(r_rest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
            r6_v   <= 1'b0;
            r_dl_v <= '0;
            r7_v   <= 1'b0;
            r8_v   <= 1'b0;
            r9_v   <= 1'b0;
            r10_v  <= 1'b0;
            r11_v  <= 1'b0;
        end else if (en) begin
            r1_v   <= i_valid;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r4_v   <= r3_v;
            r5_v   <= r4_v;
            r6_v   <= r5_v;
            r_dl_v <= {r_dl_v[DIVQ_W-2:0], r6_v};
            r7_v   <= r_dl_v[DIVQ_W-1];
            r8_v   <= r7_v;
            r9_v   <= r8_v;
            r10_v  <= r9_v;
            r11_v  <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [47:0] pmx;
        logic [13:0] rxm, rym;
        logic signed [48:0] p;
        logic [28:0] n2;
        logic [63:0] ax, ay;
        if (en) begin
            // differences
            r1_sd  <= '{tag: i_pair_tag, avx: i_a_vel_x, avy: i_a_vel_y,
                        bvx: i_b_vel_x, bvy: i_b_vel_y};
            r1_dx  <= 33'(i_a_pos_x) - 33'(i_b_pos_x);
            r1_dy  <= 33'(i_a_pos_y) - 33'(i_b_pos_y);
            r1_dvx <= 33'(i_a_vel_x) - 33'(i_b_vel_x);
            r1_dvy <= 33'(i_a_vel_y) - 33'(i_b_vel_y);
            r1_am  <= i_a_mass;
            r1_bm  <= i_b_mass;
            r1_rs  <= i_radius_sum;

            // squares, dot terms, normalizing shift
            r2_sd  <= r1_sd;
            r2_sqx <= 64'(s2_mdx) * 64'(s2_mdx);
            r2_sqy <= 64'(s2_mdy) * 64'(s2_mdy);
            r2_rs2 <= 64'(r1_rs) * 64'(r1_rs);
            r2_pdx <= 66'(r1_dx) * 66'(r1_dvx);
            r2_pdy <= 66'(r1_dy) * 66'(r1_dvy);
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_dvx <= r1_dvx;
            r2_dvy <= r1_dvy;
            r2_k   <= (s2_bl > 6'(NORM_BITS)) ? 5'(s2_bl - 6'(NORM_BITS)) : 5'd0;
            r2_am  <= r1_am;
            r2_bm  <= r1_bm;

            // collision test and reduced direction
            r3_sd  <= r2_sd;
            r3_hit <= ((65'(r2_sqx) + 65'(r2_sqy)) < 65'(r2_rs2)) &&
                      ((67'(r2_pdx) + 67'(r2_pdy)) < 67'sd0);
            rxm = 14'(mag33(r2_dx) >> r2_k);
            rym = 14'(mag33(r2_dy) >> r2_k);
            r3_rx  <= r2_dx[32] ? -$signed({1'b0, rxm}) : $signed({1'b0, rxm});
            r3_ry  <= r2_dy[32] ? -$signed({1'b0, rym}) : $signed({1'b0, rym});
            r3_dvx <= r2_dvx;
            r3_dvy <= r2_dvy;
            r3_msum <= 33'(r2_am) + 33'(r2_bm);
            r3_bm  <= r2_bm;

            // projection terms
            r4_sd   <= r3_sd;
            r4_hit  <= r3_hit;
            r4_px   <= 48'(r3_dvx) * 48'(r3_rx);
            r4_py   <= 48'(r3_dvy) * 48'(r3_ry);
            rxm = r3_rx[14] ? 14'(-r3_rx) : 14'(r3_rx);
            rym = r3_ry[14] ? 14'(-r3_ry) : 14'(r3_ry);
            r4_nx   <= 28'(rxm) * 28'(rxm);
            r4_ny   <= 28'(rym) * 28'(rym);
            r4_rx   <= r3_rx;
            r4_ry   <= r3_ry;
            r4_msum <= r3_msum;
            r4_bm   <= r3_bm;

            // clamp p, norm
            r5_sd  <= r4_sd;
            r5_hit <= r4_hit;
            p  = 49'(r4_px) + 49'(r4_py);
            r5_pm  <= p[48] ? 48'(-p) : 48'd0;
            n2 = 29'(r4_nx) + 29'(r4_ny);
            r5_n2  <= (n2 == '0) ? 29'd1 : n2;
            r5_rx  <= r4_rx;
            r5_ry  <= r4_ry;
            r5_msum <= r4_msum;
            r5_bm  <= r4_bm;

            // divider operands
            r6_sd  <= r5_sd;
            r6_hit <= r5_hit;
            pmx = r5_pm;
            rxm = r5_rx[14] ? 14'(-r5_rx) : 14'(r5_rx);
            rym = r5_ry[14] ? 14'(-r5_ry) : 14'(r5_ry);
            r6_nx  <= 62'(pmx) * 62'(rxm);
            r6_ny  <= 62'(pmx) * 62'(rym);
            r6_sx  <= !r5_rx[14];
            r6_sy  <= !r5_ry[14];
            r6_n2  <= r5_n2;
            r6_wz  <= (r5_msum == '0);
            r6_wdiv <= {16'd0, r5_bm, 16'd0};
            r6_wdvs <= (r5_msum == '0) ? 33'd1 : r5_msum;

            // align sideband with the dividers
            for (int s = 0; s < DIVQ_W; s++) begin
                if (s == 0) begin
                    r_dl[s] <= '{sd: r6_sd, hit: r6_hit, sx: r6_sx, sy: r6_sy, wz: r6_wz};
                end else begin
                    r_dl[s] <= r_dl[s-1];
                end
            end

            // times (1 + e)
            r7_sd  <= r_dl[DIVQ_W-1].sd;
            r7_hit <= r_dl[DIVQ_W-1].hit;
            r7_sx  <= r_dl[DIVQ_W-1].sx;
            r7_sy  <= r_dl[DIVQ_W-1].sy;
            r7_wb  <= r_dl[DIVQ_W-1].wz ? W_HALF : q_w[16:0];
            r7_xl  <= 40'(q_x[23:0]) * 40'(fac);
            r7_xh  <= 40'(q_x[47:24]) * 40'(fac);
            r7_yl  <= 40'(q_y[23:0]) * 40'(fac);
            r7_yh  <= 40'(q_y[47:24]) * 40'(fac);

            // divide by one in Q2.14
            r8_sd  <= r7_sd;
            r8_hit <= r7_hit;
            r8_sx  <= r7_sx;
            r8_sy  <= r7_sy;
            ax = (64'(r7_xh) << 24) + 64'(r7_xl);
            ay = (64'(r7_yh) << 24) + 64'(r7_yl);
            r8_tx  <= 50'(ax >> 14);
            r8_ty  <= 50'(ay >> 14);
            r8_wb  <= r7_wb;
            r8_wa  <= W_ONE - r7_wb;

            // times weights
            r9_sd  <= r8_sd;
            r9_hit <= r8_hit;
            r9_sx  <= r8_sx;
            r9_sy  <= r8_sy;
            r9_xbl <= 42'(r8_tx[24:0]) * 42'(r8_wb);
            r9_xbh <= 42'(r8_tx[49:25]) * 42'(r8_wb);
            r9_ybl <= 42'(r8_ty[24:0]) * 42'(r8_wb);
            r9_ybh <= 42'(r8_ty[49:25]) * 42'(r8_wb);
            r9_xal <= 42'(r8_tx[24:0]) * 42'(r8_wa);
            r9_xah <= 42'(r8_tx[49:25]) * 42'(r8_wa);
            r9_yal <= 42'(r8_ty[24:0]) * 42'(r8_wa);
            r9_yah <= 42'(r8_ty[49:25]) * 42'(r8_wa);

            // divide by weight one
            r10_sd  <= r9_sd;
            r10_hit <= r9_hit;
            r10_sx  <= r9_sx;
            r10_sy  <= r9_sy;
            r10_axm <= 51'(((68'(r9_xbh) << 25) + 68'(r9_xbl)) >> 16);
            r10_aym <= 51'(((68'(r9_ybh) << 25) + 68'(r9_ybl)) >> 16);
            r10_bxm <= 51'(((68'(r9_xah) << 25) + 68'(r9_xal)) >> 16);
            r10_bym <= 51'(((68'(r9_yah) << 25) + 68'(r9_yal)) >> 16);

            // output register
            o_tag_out  <= r10_sd.tag;
            o_collided <= r10_hit;
            if (r10_hit) begin
                o_new_a_vel_x <= apply(r10_sd.avx, r10_sx, r10_axm, 1'b1);
                o_new_a_vel_y <= apply(r10_sd.avy, r10_sy, r10_aym, 1'b1);
                o_new_b_vel_x <= apply(r10_sd.bvx, r10_sx, r10_bxm, 1'b0);
                o_new_b_vel_y <= apply(r10_sd.bvy, r10_sy, r10_bym, 1'b0);
            end else begin
                o_new_a_vel_x <= r10_sd.avx;
                o_new_a_vel_y <= r10_sd.avy;
                o_new_b_vel_x <= r10_sd.bvx;
                o_new_b_vel_y <= r10_sd.bvy;
            end
        end
    end

    assign o_valid = r11_v;

    dcr_div u_div_x (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (64'(r6_nx)),
        .i_divisor  (33'(r6_n2)),
        .o_quot     (q_x)
    );

    dcr_div u_div_y (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (64'(r6_ny)),
        .i_divisor  (33'(r6_n2)),
        .o_quot     (q_y)
    );

    dcr_div u_div_w (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r6_wdiv),
        .i_divisor  (r6_wdvs),
        .o_quot     (q_w)
    );

    `DCR_ASSERT_IMPLIES(a_hit_norm, r5_v && r5_hit, r5_n2 != '0, "zero norm on a collision")
    `DCR_ASSERT_NEVER(a_wt_range, r_dl_v[DIVQ_W-1] && !r_dl[DIVQ_W-1].wz && (q_w > 48'd65536), "mass weight above one")

endmodule
